/* rtl/core/drp_pkg.sv */
// ============================================================================
// drp_pkg - shared types and constants of the dead-reckoning pose integrator
// Beat layouts, fixed-point limits, CORDIC settings and the arctangent table.
// ============================================================================
package drp_pkg;

    // Iterations of the sine/cosine unit, limited by the arctangent table.
    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ITER_W        = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

    // CORDIC datapath width: Q2.30 values with headroom for the gain.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Position range, millimetres with 8 fractional bits.
    localparam int POS_W = 40;
    localparam logic signed [POS_W:0] POS_MAX = 41'sd549755813887;
    localparam logic signed [POS_W:0] POS_MIN = -41'sd549755813888;

    // Degree handling: an offset that is a multiple of a full turn keeps the
    // dividend positive. The step is (deg * 65536 + 180) / 360, taken as
    // (deg * 8192 + 22) / 45, which a reciprocal multiplication gives exactly
    // for every dividend below 2^30.
    localparam logic [16:0] DEG_OFFSET = 17'd33120;
    localparam logic [29:0] DEG_BIAS   = 30'd22;
    localparam logic [30:0] DEG_RECIP  = 31'd1527099484;
    localparam int          DEG_SHIFT  = 36;

    typedef struct packed {
        logic signed [15:0] angle_deg;
        logic signed [15:0] distance_mm;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic signed [15:0]      heading;
    } out_t;

    // Work handed from the front to the back: heading step and distance.
    typedef struct packed {
        logic [15:0]        delta;
        logic signed [15:0] distance_mm;
    } cmd_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [CW-1:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return $signed({{(CW-32){1'b0}}, v});
    endfunction

endpackage

/* rtl/core/dead_reckoning_pose_integrator.sv */
// ============================================================================
// dead_reckoning_pose_integrator - odometry pose accumulator
// Integrates heading change and travelled distance into an X/Y/heading pose.
// ============================================================================
// Each input beat carries a heading change in whole degrees and a distance in
// millimetres. The block converts the degrees to a 16-bit binary angle
// (32768 units are half a turn), adds it to the stored heading with natural
// wrap, computes cosine and sine of the new heading in Q1.15 with an iterative
// CORDIC, and adds distance times cosine and sine to the stored X and Y. X and
// Y are millimetres with 8 fractional bits and saturate at the 40-bit range.
// One result beat is produced per input beat, in order. The front end turns
// the degree count into a heading step with a reciprocal multiplication; per
// beat it accepts the beat, multiplies, and hands the step to the queue,
// waiting there while the queue is full. The back end pops a step, runs the
// CORDIC iterations, rounds, multiplies by the distance and accumulates, and
// holds the last step while the output register still has an unread result.
// A two-entry queue between them lets both overlap, so the sustained rate is
// set by the back end. Full is raised while the front end holds a beat, and a
// finished result waits in an output register while the next beat is being
// worked on.
// Both stored pose and heading clear to zero on reset.
// ============================================================================
module dead_reckoning_pose_integrator
    import drp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic empty,
    input  logic pop,
    output out_t result
);

    logic cmd_push_w;
    logic cmd_full_w;
    logic cmd_pop_w;
    logic cmd_empty_w;
    cmd_t cmd_wr;
    cmd_t cmd_rd;

    // Front: degrees to binary angle step.
    drp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push_w),
        .cmd_full (cmd_full_w),
        .cmd      (cmd_wr)
    );

    // Short queue so the conversion of the next beat overlaps the pose update.
    drp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push_w),
        .full    (cmd_full_w),
        .wr_data (cmd_wr),
        .pop     (cmd_pop_w),
        .empty   (cmd_empty_w),
        .rd_data (cmd_rd)
    );

    // Back: heading accumulation, CORDIC, scaling and saturating position.
    drp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty_w),
        .cmd_pop   (cmd_pop_w),
        .cmd       (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* rtl/core/drp_front.sv */
// ============================================================================
// drp_front - degree to binary angle conversion
// Scales the degree count to a 16-bit binary angle step with a reciprocal
// multiplication; whole turns fall out of the low 16 bits of the quotient.
// ============================================================================
module drp_front
    import drp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic cmd_push,
    input  logic cmd_full,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } state_t;

    state_t             state_reg, state_next;
    logic [29:0]        num_reg, num_next;
    logic [15:0]        delta_reg, delta_next;
    logic signed [15:0] dist_reg, dist_next;

    logic [16:0]        turns;
    logic [60:0]        product;

    assign turns   = {item.angle_deg[15], item.angle_deg} + DEG_OFFSET;
    assign product = {31'd0, num_reg} * {30'd0, DEG_RECIP};

    assign full            = (state_reg != ST_IDLE);
    assign cmd_push        = (state_reg == ST_SEND);
    assign cmd.delta       = delta_reg;
    assign cmd.distance_mm = dist_reg;

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        delta_next = delta_reg;
        dist_next  = dist_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    num_next   = {turns, 13'd0} + DEG_BIAS;
                    dist_next  = item.distance_mm;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                delta_next = product[DEG_SHIFT +: 16];
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!cmd_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        delta_reg <= delta_next;
        dist_reg  <= dist_next;
    end

endmodule

/* rtl/core/drp_queue.sv */
// ============================================================================
// drp_queue - two-entry command queue
// Decouples the angle conversion from the pose update.
// ============================================================================
module drp_queue
    import drp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t wr_data,
    input  logic pop,
    output logic empty,
    output cmd_t rd_data
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/drp_back.sv */
// ============================================================================
// drp_back - pose update
// Accumulates the heading, runs an iterative CORDIC for sine and cosine,
// scales by distance and adds to the saturating X/Y position.
// ============================================================================
module drp_back
    import drp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  cmd_t cmd,
    output logic empty,
    input  logic pop,
    output out_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND,
        ST_MUL,
        ST_ACC
    } state_t;

    localparam logic signed [CW-1:0] HALF_LSB = 34'sd16384;
    localparam logic signed [CW-1:0] Q15_MAX  = 34'sd32767;
    localparam logic signed [CW-1:0] Q15_MIN  = -34'sd32768;

    state_t                   state_reg, state_next;
    logic [15:0]              head_reg, head_next;
    logic                     flip_reg, flip_next;
    logic signed [CW-1:0]     x_reg, x_next;
    logic signed [CW-1:0]     y_reg, y_next;
    logic signed [CW-1:0]     z_reg, z_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic signed [15:0]       dist_reg, dist_next;
    logic signed [15:0]       cos_reg, cos_next;
    logic signed [15:0]       sin_reg, sin_next;
    logic signed [31:0]       px_reg, px_next;
    logic signed [31:0]       py_reg, py_next;
    logic signed [POS_W-1:0]  pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]  pos_y_reg, pos_y_next;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg, out_next;

    logic [15:0]              head_sum;
    logic                     quad_flip;
    logic signed [CW-1:0]     xs, ys, atan;
    logic signed [24:0]       inc_x, inc_y;
    logic signed [POS_W-1:0]  sat_x, sat_y;
    logic                     out_free;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] w;
        w = (v + HALF_LSB) >>> 15;
        if (w > Q15_MAX)
        begin
            w = Q15_MAX;
        end
        else if (w < Q15_MIN)
        begin
            w = Q15_MIN;
        end
        return w[15:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [24:0]      b
    );
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + {{(POS_W-24){b[24]}}, b};
        if (s > POS_MAX)
        begin
            s = POS_MAX;
        end
        else if (s < POS_MIN)
        begin
            s = POS_MIN;
        end
        return s[POS_W-1:0];
    endfunction

    assign head_sum  = head_reg + cmd.delta;
    // Left half plane: rotate by half a turn and negate the results.
    assign quad_flip = head_sum[15] ^ head_sum[14];
    assign xs        = x_reg >>> cnt_reg;
    assign ys        = y_reg >>> cnt_reg;
    assign atan      = atan_turns(5'(cnt_reg));
    assign inc_x     = 25'((px_reg + 32'sd64) >>> 7);
    assign inc_y     = 25'((py_reg + 32'sd64) >>> 7);
    assign sat_x     = sat_add(pos_x_reg, inc_x);
    assign sat_y     = sat_add(pos_y_reg, inc_y);
    assign out_free  = !out_valid_reg || pop;

    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        flip_next      = flip_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        cnt_next       = cnt_reg;
        dist_next      = dist_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    head_next  = head_sum;
                    flip_next  = quad_flip;
                    x_next     = CORDIC_GAIN;
                    y_next     = '0;
                    z_next     = {{(CW-32){head_sum[15] ^ quad_flip}},
                                  head_sum[15] ^ quad_flip, head_sum[14:0], 16'd0};
                    cnt_next   = '0;
                    dist_next  = cmd.distance_mm;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (!z_reg[CW-1])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cos_next   = to_q15(flip_reg ? -x_reg : x_reg);
                sin_next   = to_q15(flip_reg ? -y_reg : y_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                px_next    = dist_reg * cos_reg;
                py_next    = dist_reg * sin_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    pos_x_next     = sat_x;
                    pos_y_next     = sat_y;
                    out_next.x_pos = sat_x;
                    out_next.y_pos = sat_y;
                    out_next.heading = head_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        dist_reg <= dist_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        out_reg  <= out_next;
    end

endmodule
